>>> rtl/scs_pkg.sv
// Shared types and constants of the stick command shaper.
// No dependencies; imported by the core and by its port checker.
`default_nettype none

package scs_pkg;

    // Field widths
    localparam int unsigned PULSE_W = 15;
    localparam int unsigned CMD_W   = 16;
    localparam int unsigned GAIN_W  = 8;
    localparam int unsigned CFG_W   = 16;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned TICK_W  = 4;
    localparam int unsigned PROD_W  = 2 * CMD_W;
    localparam int unsigned BAND_W  = 4;

    // Shaping constants
    localparam logic signed [CMD_W-1:0] SLEW_LIMIT = 16'sd1092;
    localparam logic [BAND_W-1:0]       RP_BAND    = 4'd4;
    localparam logic [BAND_W-1:0]       YAW_BAND   = 4'd10;
    localparam logic [TICK_W-1:0]       TICK_LAST  = 4'd7;

    // Register reset values
    localparam logic [GAIN_W-1:0]       GAIN_RST  = 8'd1;
    localparam logic signed [CMD_W-1:0] COS_RST   = 16'sd23170;
    localparam logic signed [CMD_W-1:0] SIN_RST   = -16'sd23170;
    localparam logic [PULSE_W-1:0]      TRIM_RST  = 15'd3000;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ANGLE_MODE    = 3'd0,
        CFG_TILT_GAIN     = 3'd1,
        CFG_X_FRAME       = 3'd2,
        CFG_FRAME_COS     = 3'd3,
        CFG_FRAME_SIN     = 3'd4,
        CFG_AILERON_TRIM  = 3'd5,
        CFG_ELEVATOR_TRIM = 3'd6,
        CFG_RUDDER_TRIM   = 3'd7
    } cfg_idx_t;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ROLL_MUL,
        ST_ROLL_ACC,
        ST_PITCH_ACC,
        ST_YAW_ACC,
        ST_ROT_RC,
        ST_ROT_PS,
        ST_ROT_RS,
        ST_ROT_PC,
        ST_FINISH
    } state_t;

endpackage

`default_nettype wire

>>> rtl/stick_command_shaper_core.sv
// Stick command shaper core: sequencer, shared multiplier and shared axis unit.
// Depends on scs_pkg.
`default_nettype none

// One beat in, one beat out per control tick. A wrapping tick counter lets
// every ninth tick recompute roll, pitch and yaw; other ticks return the held
// commands with updated low. A held tick goes straight from idle to the
// finish state; an updating tick steps through roll, pitch and yaw first,
// and with the X-frame rotation enabled also through the four rotation
// products. The finish state loads the result register once it is free, and
// the input is ready again as soon as that register is loaded. The steps come from the
// single 16x16 multiplier and the single deadband/clamp/add unit, which the
// sequencer steps through roll, pitch, yaw and the four rotation products.
// A finished result waits in the output register while the next beat is
// taken. Configuration writes are meant for idle periods only.
module stick_command_shaper_core (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // configuration write port
    input  wire logic                          cfg_write_en,
    input  wire logic [scs_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [scs_pkg::CFG_W-1:0]     cfg_data,
    // input channel
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [scs_pkg::PULSE_W-1:0]   aileron_pulse,
    input  wire logic [scs_pkg::PULSE_W-1:0]   elevator_pulse,
    input  wire logic [scs_pkg::PULSE_W-1:0]   rudder_pulse,
    // output channel
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic signed [scs_pkg::CMD_W-1:0]   roll_command,
    output logic signed [scs_pkg::CMD_W-1:0]   pitch_command,
    output logic signed [scs_pkg::CMD_W-1:0]   yaw_command,
    output logic                               updated
);
    import scs_pkg::*;

    // Configuration registers
    logic                     angle_mode_reg, angle_mode_next;
    logic [GAIN_W-1:0]        tilt_gain_reg, tilt_gain_next;
    logic                     x_frame_reg, x_frame_next;
    logic signed [CMD_W-1:0]  cos_reg, cos_next;
    logic signed [CMD_W-1:0]  sin_reg, sin_next;
    logic [PULSE_W-1:0]       ail_trim_reg, ail_trim_next;
    logic [PULSE_W-1:0]       ele_trim_reg, ele_trim_next;
    logic [PULSE_W-1:0]       rud_trim_reg, rud_trim_next;

    // Control and state
    state_t                   state_reg, state_next;
    logic [TICK_W-1:0]        tick_reg, tick_next;
    logic                     upd_reg, upd_next;
    logic                     out_valid_reg, out_valid_next;
    logic signed [CMD_W-1:0]  cmd_roll_reg, cmd_roll_next;
    logic signed [CMD_W-1:0]  cmd_pitch_reg, cmd_pitch_next;
    logic signed [CMD_W-1:0]  cmd_yaw_reg, cmd_yaw_next;
    logic signed [CMD_W-1:0]  last_roll_reg, last_roll_next;
    logic signed [CMD_W-1:0]  last_pitch_reg, last_pitch_next;

    // Datapath payload
    logic [PULSE_W-1:0]       ail_reg, ail_next;
    logic [PULSE_W-1:0]       ele_reg, ele_next;
    logic [PULSE_W-1:0]       rud_reg, rud_next;
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic signed [PROD_W-1:0] acc_reg, acc_next;
    logic signed [CMD_W-1:0]  roll_tmp_reg, roll_tmp_next;
    logic signed [CMD_W-1:0]  out_roll_reg, out_roll_next;
    logic signed [CMD_W-1:0]  out_pitch_reg, out_pitch_next;
    logic signed [CMD_W-1:0]  out_yaw_reg, out_yaw_next;
    logic                     out_upd_reg, out_upd_next;

    // Combinational datapath signals
    logic signed [CMD_W-1:0]  off_roll, off_pitch, off_yaw;
    logic signed [CMD_W-1:0]  stick_gain;
    logic signed [CMD_W-1:0]  mul_a, mul_b;
    logic                     ax_angle;
    logic [BAND_W-1:0]        ax_band;
    logic signed [CMD_W-1:0]  ax_base;
    logic signed [CMD_W-1:0]  ax_last;
    logic signed [CMD_W-1:0]  ax_in;
    logic signed [CMD_W-1:0]  ax_band_s;
    logic signed [CMD_W-1:0]  ax_pre;
    logic signed [CMD_W-1:0]  ax_delta;
    logic signed [CMD_W-1:0]  ax_result;
    logic signed [PROD_W-1:0] rot_sum;
    logic signed [CMD_W-1:0]  rot_twice;
    logic                     accept;

    assign in_ready      = (state_reg == ST_IDLE);
    assign accept        = in_valid && in_ready;
    assign out_valid     = out_valid_reg;
    assign roll_command  = out_roll_reg;
    assign pitch_command = out_pitch_reg;
    assign yaw_command   = out_yaw_reg;
    assign updated       = out_upd_reg;

    // Trim-relative stick offsets, always within 16-bit signed range
    assign off_roll  = $signed({1'b0, ail_reg}) - $signed({1'b0, ail_trim_reg});
    assign off_pitch = $signed({1'b0, ele_reg}) - $signed({1'b0, ele_trim_reg});
    assign off_yaw   = $signed({1'b0, rud_reg}) - $signed({1'b0, rud_trim_reg});
    assign stick_gain = angle_mode_reg ? $signed({{(CMD_W-GAIN_W){1'b0}}, tilt_gain_reg})
                                       : 16'sd1;

    // Shared multiplier operand select
    always_comb
    begin
        case (state_reg)
            ST_ROLL_MUL:
            begin
                mul_a = off_roll;
                mul_b = stick_gain;
            end
            ST_ROLL_ACC:
            begin
                mul_a = off_pitch;
                mul_b = stick_gain;
            end
            ST_PITCH_ACC:
            begin
                mul_a = off_yaw;
                mul_b = 16'sd1;
            end
            ST_YAW_ACC:
            begin
                mul_a = cmd_roll_reg;
                mul_b = cos_reg;
            end
            ST_ROT_RC:
            begin
                mul_a = cmd_pitch_reg;
                mul_b = sin_reg;
            end
            ST_ROT_PS:
            begin
                mul_a = cmd_roll_reg;
                mul_b = sin_reg;
            end
            ST_ROT_RS:
            begin
                mul_a = cmd_pitch_reg;
                mul_b = cos_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Shared axis unit: deadband or slew difference, clamp, wrapping add
    always_comb
    begin
        case (state_reg)
            ST_ROLL_ACC:
            begin
                ax_angle = angle_mode_reg;
                ax_band  = RP_BAND;
                ax_last  = last_roll_reg;
                ax_base  = angle_mode_reg ? last_roll_reg : cmd_roll_reg;
            end
            ST_PITCH_ACC:
            begin
                ax_angle = angle_mode_reg;
                ax_band  = RP_BAND;
                ax_last  = last_pitch_reg;
                ax_base  = angle_mode_reg ? last_pitch_reg : cmd_pitch_reg;
            end
            default:
            begin
                ax_angle = 1'b0;
                ax_band  = YAW_BAND;
                ax_last  = '0;
                ax_base  = cmd_yaw_reg;
            end
        endcase

        ax_in = prod_reg[CMD_W-1:0];
        if (ax_in >= $signed({{(CMD_W-BAND_W){1'b0}}, ax_band}))
            ax_band_s = ax_in - $signed({{(CMD_W-BAND_W){1'b0}}, ax_band});
        else if (ax_in <= -$signed({{(CMD_W-BAND_W){1'b0}}, ax_band}))
            ax_band_s = ax_in + $signed({{(CMD_W-BAND_W){1'b0}}, ax_band});
        else
            ax_band_s = '0;

        ax_pre = ax_angle ? (ax_in - ax_last) : ax_band_s;

        if (ax_pre > SLEW_LIMIT)
            ax_delta = SLEW_LIMIT;
        else if (ax_pre < -SLEW_LIMIT)
            ax_delta = -SLEW_LIMIT;
        else
            ax_delta = ax_pre;

        ax_result = ax_base + ax_delta;
    end

    // Rotation accumulator: high word of the 32-bit sum, times two
    assign rot_sum   = (state_reg == ST_ROT_PS) ? (acc_reg - prod_reg) : (acc_reg + prod_reg);
    assign rot_twice = {rot_sum[PROD_W-2:CMD_W], 1'b0};

    // Next state and datapath control
    always_comb
    begin
        angle_mode_next = angle_mode_reg;
        tilt_gain_next  = tilt_gain_reg;
        x_frame_next    = x_frame_reg;
        cos_next        = cos_reg;
        sin_next        = sin_reg;
        ail_trim_next   = ail_trim_reg;
        ele_trim_next   = ele_trim_reg;
        rud_trim_next   = rud_trim_reg;

        state_next      = state_reg;
        tick_next       = tick_reg;
        upd_next        = upd_reg;
        out_valid_next  = out_valid_reg;
        cmd_roll_next   = cmd_roll_reg;
        cmd_pitch_next  = cmd_pitch_reg;
        cmd_yaw_next    = cmd_yaw_reg;
        last_roll_next  = last_roll_reg;
        last_pitch_next = last_pitch_reg;

        ail_next        = ail_reg;
        ele_next        = ele_reg;
        rud_next        = rud_reg;
        prod_next       = mul_a * mul_b;
        acc_next        = acc_reg;
        roll_tmp_next   = roll_tmp_reg;
        out_roll_next   = out_roll_reg;
        out_pitch_next  = out_pitch_reg;
        out_yaw_next    = out_yaw_reg;
        out_upd_next    = out_upd_reg;

        // configuration writes
        if (cfg_write_en)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_ANGLE_MODE:    angle_mode_next = cfg_data[0];
                CFG_TILT_GAIN:     tilt_gain_next  = cfg_data[GAIN_W-1:0];
                CFG_X_FRAME:       x_frame_next    = cfg_data[0];
                CFG_FRAME_COS:     cos_next        = cfg_data;
                CFG_FRAME_SIN:     sin_next        = cfg_data;
                CFG_AILERON_TRIM:  ail_trim_next   = cfg_data[PULSE_W-1:0];
                CFG_ELEVATOR_TRIM: ele_trim_next   = cfg_data[PULSE_W-1:0];
                CFG_RUDDER_TRIM:   rud_trim_next   = cfg_data[PULSE_W-1:0];
                default:           ;
            endcase
        end

        // result beat taken
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    ail_next = aileron_pulse;
                    ele_next = elevator_pulse;
                    rud_next = rudder_pulse;
                    if (tick_reg > TICK_LAST)
                    begin
                        tick_next  = '0;
                        upd_next   = 1'b1;
                        state_next = ST_ROLL_MUL;
                    end
                    else
                    begin
                        tick_next  = tick_reg + 1'b1;
                        upd_next   = 1'b0;
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_ROLL_MUL:
            begin
                state_next = ST_ROLL_ACC;
            end
            ST_ROLL_ACC:
            begin
                cmd_roll_next = ax_result;
                if (angle_mode_reg)
                    last_roll_next = ax_result;
                state_next = ST_PITCH_ACC;
            end
            ST_PITCH_ACC:
            begin
                cmd_pitch_next = ax_result;
                if (angle_mode_reg)
                    last_pitch_next = ax_result;
                state_next = ST_YAW_ACC;
            end
            ST_YAW_ACC:
            begin
                cmd_yaw_next = ax_result;
                state_next   = x_frame_reg ? ST_ROT_RC : ST_FINISH;
            end
            ST_ROT_RC:
            begin
                acc_next   = prod_reg;
                state_next = ST_ROT_PS;
            end
            ST_ROT_PS:
            begin
                roll_tmp_next = rot_twice;
                state_next    = ST_ROT_RS;
            end
            ST_ROT_RS:
            begin
                acc_next   = prod_reg;
                state_next = ST_ROT_PC;
            end
            ST_ROT_PC:
            begin
                cmd_roll_next  = roll_tmp_reg;
                cmd_pitch_next = rot_twice;
                state_next     = ST_FINISH;
            end
            ST_FINISH:
            begin
                // load the output register once it is free
                if (!out_valid_reg || out_ready)
                begin
                    out_roll_next  = cmd_roll_reg;
                    out_pitch_next = cmd_pitch_reg;
                    out_yaw_next   = cmd_yaw_reg;
                    out_upd_next   = upd_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State, configuration and command registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            angle_mode_reg <= 1'b0;
            tilt_gain_reg  <= GAIN_RST;
            x_frame_reg    <= 1'b0;
            cos_reg        <= COS_RST;
            sin_reg        <= SIN_RST;
            ail_trim_reg   <= TRIM_RST;
            ele_trim_reg   <= TRIM_RST;
            rud_trim_reg   <= TRIM_RST;
            state_reg      <= ST_IDLE;
            tick_reg       <= '0;
            upd_reg        <= 1'b0;
            out_valid_reg  <= 1'b0;
            cmd_roll_reg   <= '0;
            cmd_pitch_reg  <= '0;
            cmd_yaw_reg    <= '0;
            last_roll_reg  <= '0;
            last_pitch_reg <= '0;
        end
        else
        begin
            angle_mode_reg <= angle_mode_next;
            tilt_gain_reg  <= tilt_gain_next;
            x_frame_reg    <= x_frame_next;
            cos_reg        <= cos_next;
            sin_reg        <= sin_next;
            ail_trim_reg   <= ail_trim_next;
            ele_trim_reg   <= ele_trim_next;
            rud_trim_reg   <= rud_trim_next;
            state_reg      <= state_next;
            tick_reg       <= tick_next;
            upd_reg        <= upd_next;
            out_valid_reg  <= out_valid_next;
            cmd_roll_reg   <= cmd_roll_next;
            cmd_pitch_reg  <= cmd_pitch_next;
            cmd_yaw_reg    <= cmd_yaw_next;
            last_roll_reg  <= last_roll_next;
            last_pitch_reg <= last_pitch_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        ail_reg       <= ail_next;
        ele_reg       <= ele_next;
        rud_reg       <= rud_next;
        prod_reg      <= prod_next;
        acc_reg       <= acc_next;
        roll_tmp_reg  <= roll_tmp_next;
        out_roll_reg  <= out_roll_next;
        out_pitch_reg <= out_pitch_next;
        out_yaw_reg   <= out_yaw_next;
        out_upd_reg   <= out_upd_next;
    end

endmodule

`default_nettype wire

>>> rtl/scs_checker.sv
// Port-level checker for the stick command shaper core, bound to the core module.
// Depends on scs_pkg and stick_command_shaper_core.
`default_nettype none

module scs_checker (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    input  wire logic                          in_ready,
    input  wire logic                          out_valid,
    input  wire logic                          out_ready,
    input  wire logic signed [scs_pkg::CMD_W-1:0] roll_command,
    input  wire logic signed [scs_pkg::CMD_W-1:0] pitch_command,
    input  wire logic signed [scs_pkg::CMD_W-1:0] yaw_command,
    input  wire logic                          updated
);
    import scs_pkg::*;

    // one beat at a time: ready drops right after an input beat
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken twice in a row");

    // a result never shows up the cycle right after an input beat
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && !out_valid |=> !out_valid)
        else $error("result appeared too early");

    // stalled result beat holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(roll_command)
            && $stable(pitch_command) && $stable(yaw_command) && $stable(updated))
        else $error("stalled result beat changed");

endmodule

bind stick_command_shaper_core scs_checker u_scs_checker (.*);

`default_nettype wire
